### rtl/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, constants and codes for the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam int HEAP_BYTES   = 1024;
  localparam int ALIGN_BYTES  = 8;
  localparam int HEADER_BYTES = 16;

  localparam int HDR_BYTES   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int GRANULES    = HEAP_BYTES / ALIGN_BYTES;
  localparam int GW          = $clog2(GRANULES);
  localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
  localparam int SZ_W        = $clog2(HEAP_BYTES);
  localparam int OFF_W       = SZ_W + 2;
  localparam int REQ_W       = 16;
  localparam int REL_W       = 10;
  localparam int DATA_W      = 10;
  localparam int WANT_W      = REQ_W + 1;
  localparam int SPL_W       = WANT_W + 1;
  localparam int INIT_SIZE   = HEAP_BYTES - HDR_BYTES;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_INIT  = 2'd2;

  localparam logic [1:0] OFF_HOLD    = 2'd0;
  localparam logic [1:0] OFF_ZERO    = 2'd1;
  localparam logic [1:0] OFF_NXT_RD  = 2'd2;
  localparam logic [1:0] OFF_NXT_CUR = 2'd3;

  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_OFF  = 2'd1;
  localparam logic [1:0] RD_NXT  = 2'd2;

  localparam logic [2:0] WR_NONE    = 3'd0;
  localparam logic [2:0] WR_SPLIT   = 3'd1;
  localparam logic [2:0] WR_TAKE    = 3'd2;
  localparam logic [2:0] WR_MERGE   = 3'd3;
  localparam logic [2:0] WR_FREEBIT = 3'd4;
  localparam logic [2:0] WR_INIT    = 3'd5;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [REQ_W-1:0] request_bytes;
    logic [REL_W-1:0] release_offset;
  } ffha_in_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data_offset;
  } ffha_out_t;

  typedef struct packed {
    logic       load;
    logic [1:0] off_sel;
    logic       sz_ld;
    logic [1:0] rd_sel;
    logic [2:0] wr_sel;
    logic       res_ld;
    logic       res_ok;
    logic       res_ptr;
  } ffha_cmd_t;

  typedef struct packed {
    logic fit;
    logic split;
    logic rd_free;
    logic nxt_rd_in;
    logic off_in;
    logic rel_ok;
  } ffha_sts_t;

endpackage

`default_nettype wire

### rtl/first_fit_heap_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit heap allocator with split on allocate and coalescing on free.
//
//   channel | signals                       | payload
//   in      | in_valid_i / in_ready_o       | ffha_in_t  (cmd, request, offset)
//   out     | out_valid_o / out_ready_i     | ffha_out_t (ok, data_offset)
//
// Allocate: walks block headers from offset 0 to the first fit, splits it
// when the rest holds a header and a granule. Free: sets the free bit, then
// walks from offset 0 merging each free block with a free next neighbour.
// Reset restores the single free block at once; no clearing pass.
// A new transaction is taken while the previous result waits on out_ready_i;
// the walk stalls only in S_DONE until the result register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_heap_allocator_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ffha_pkg::ffha_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ffha_pkg::ffha_out_t out_data_o
);
  import ffha_pkg::*;

  ffha_cmd_t cmd;
  ffha_sts_t sts;

  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_cmd_i    (in_data_i.cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ffha_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.data_offset == '0)
    else $error("failed allocation returned nonzero offset");

  a_ptr_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.data_offset != '0) |->
      (out_data_o.data_offset[ALIGN_SHIFT-1:0] == '0) &&
      (out_data_o.data_offset >= DATA_W'(HDR_BYTES)))
    else $error("returned offset not on a block data start");

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second transaction taken before walk started");

  a_load_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> in_ready_o && in_valid_i)
    else $error("input latched outside an accepted transaction");

endmodule

`default_nettype wire

### rtl/ffha_dp.sv
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: header stores, walk offset, size arithmetic, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ffha_pkg::ffha_in_t  in_data_i,
  input  ffha_pkg::ffha_cmd_t cmd_i,
  output ffha_pkg::ffha_sts_t sts_o,
  output ffha_pkg::ffha_out_t out_data_o
);
  import ffha_pkg::*;

  logic [SZ_W-1:0]  size_mem [GRANULES];
  logic             free_mem [GRANULES];

  logic [SZ_W-1:0]   size_rd_q;
  logic              free_rd_q;
  logic              dflt_rd_q;
  logic              e0_valid_q;
  logic [OFF_W-1:0]  off_q;
  logic [SZ_W-1:0]   cur_sz_q;
  logic [WANT_W-1:0] want_q;
  logic [GW-1:0]     rel_g_q;
  ffha_out_t         res_q;

  logic [SZ_W-1:0]   rd_size;
  logic              rd_free;
  logic [OFF_W-1:0]  nxt_rd;
  logic [OFF_W-1:0]  nxt_cur;
  logic [SPL_W-1:0]  split_addr;
  logic [WANT_W-1:0] want_in;
  logic [REL_W-1:0]  rel_h;
  logic              rd_en;
  logic [OFF_W-1:0]  rd_addr;
  logic              wr_size_en;
  logic              wr_free_en;
  logic [SPL_W-1:0]  wr_addr;
  logic [SZ_W-1:0]   wr_size;
  logic              wr_free;
  logic              wr_in;

  // entry 0 reads as the initial block until its size is first written
  assign rd_size = dflt_rd_q ? SZ_W'(INIT_SIZE) : size_rd_q;
  assign rd_free = dflt_rd_q | free_rd_q;

  assign nxt_rd     = off_q + OFF_W'(HDR_BYTES) + OFF_W'(rd_size);
  assign nxt_cur    = off_q + OFF_W'(HDR_BYTES) + OFF_W'(cur_sz_q);
  assign split_addr = SPL_W'(off_q) + SPL_W'(HDR_BYTES) + SPL_W'(want_q);
  assign want_in    = (WANT_W'(in_data_i.request_bytes) + WANT_W'(ALIGN_BYTES - 1))
                      & ~WANT_W'(ALIGN_BYTES - 1);
  assign rel_h      = in_data_i.release_offset - REL_W'(HDR_BYTES);

  assign sts_o.rd_free   = rd_free;
  assign sts_o.fit       = rd_free && (WANT_W'(rd_size) >= want_q);
  assign sts_o.split     = SPL_W'(rd_size) >= (SPL_W'(want_q) + SPL_W'(HDR_BYTES + ALIGN_BYTES));
  assign sts_o.nxt_rd_in = nxt_rd < OFF_W'(HEAP_BYTES);
  assign sts_o.off_in    = off_q < OFF_W'(HEAP_BYTES);
  assign sts_o.rel_ok    = (OFF_W'(in_data_i.release_offset) >= OFF_W'(HDR_BYTES))
                           && (rel_h[ALIGN_SHIFT-1:0] == '0)
                           && (OFF_W'(rel_h) < OFF_W'(HEAP_BYTES));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = off_q;
    case (cmd_i.rd_sel)
      RD_OFF: begin
        rd_en   = 1'b1;
        rd_addr = off_q;
      end
      RD_NXT: begin
        rd_en   = 1'b1;
        rd_addr = nxt_rd;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_size_en = 1'b0;
    wr_free_en = 1'b0;
    wr_addr    = SPL_W'(off_q);
    wr_size    = rd_size;
    wr_free    = 1'b1;
    case (cmd_i.wr_sel)
      WR_SPLIT: begin
        wr_size_en = 1'b1;
        wr_free_en = 1'b1;
        wr_addr    = split_addr;
        wr_size    = SZ_W'(rd_size - SZ_W'(want_q) - SZ_W'(HDR_BYTES));
      end
      WR_TAKE: begin
        wr_size_en = 1'b1;
        wr_free_en = 1'b1;
        wr_size    = sts_o.split ? SZ_W'(want_q) : rd_size;
        wr_free    = 1'b0;
      end
      WR_MERGE: begin
        wr_size_en = 1'b1;
        wr_free_en = 1'b1;
        wr_size    = SZ_W'(cur_sz_q + SZ_W'(HDR_BYTES) + rd_size);
      end
      WR_FREEBIT: begin
        wr_free_en = 1'b1;
        wr_addr    = SPL_W'({rel_g_q, {ALIGN_SHIFT{1'b0}}});
      end
      WR_INIT: begin
        wr_size_en = 1'b1;
        wr_free_en = 1'b1;
        wr_addr    = '0;
        wr_size    = SZ_W'(INIT_SIZE);
      end
      default: begin
        wr_size_en = 1'b0;
      end
    endcase
  end

  assign wr_in = wr_addr < SPL_W'(HEAP_BYTES);

  always_ff @(posedge clk_i) begin
    if (wr_size_en && wr_in) begin
      size_mem[wr_addr[ALIGN_SHIFT +: GW]] <= wr_size;
    end
    if (wr_free_en && wr_in) begin
      free_mem[wr_addr[ALIGN_SHIFT +: GW]] <= wr_free;
    end
    if (rd_en) begin
      size_rd_q <= size_mem[rd_addr[ALIGN_SHIFT +: GW]];
      free_rd_q <= free_mem[rd_addr[ALIGN_SHIFT +: GW]];
      dflt_rd_q <= (rd_addr[ALIGN_SHIFT +: GW] == '0) && !e0_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e0_valid_q <= 1'b0;
    end else if (wr_size_en && (wr_addr == '0)) begin
      e0_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      want_q  <= want_in;
      rel_g_q <= rel_h[ALIGN_SHIFT +: GW];
    end
    if (cmd_i.sz_ld) begin
      cur_sz_q <= rd_size;
    end
    case (cmd_i.off_sel)
      OFF_ZERO:    off_q <= '0;
      OFF_NXT_RD:  off_q <= nxt_rd;
      OFF_NXT_CUR: off_q <= nxt_cur;
      default:     off_q <= off_q;
    endcase
    if (cmd_i.res_ld) begin
      res_q.ok          <= cmd_i.res_ok;
      res_q.data_offset <= cmd_i.res_ptr ? DATA_W'(off_q + OFF_W'(HDR_BYTES)) : '0;
    end
  end

  assign out_data_o = res_q;

endmodule

`default_nettype wire

### rtl/ffha_ctrl.sv
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller: sequences allocate, free/merge and reinit walks; owns handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ffha_pkg::ffha_sts_t sts_i,
  output ffha_pkg::ffha_cmd_t cmd_o
);
  import ffha_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_A_RD  = 4'd1;
  localparam logic [3:0] S_A_EV  = 4'd2;
  localparam logic [3:0] S_A_WR  = 4'd3;
  localparam logic [3:0] S_FREE  = 4'd4;
  localparam logic [3:0] S_M_RD  = 4'd5;
  localparam logic [3:0] S_M_EV  = 4'd6;
  localparam logic [3:0] S_M_EV2 = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state_q, state_d;
  logic       ok_q, ok_d;
  logic       ptr_q, ptr_d;
  logic       out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    ok_d        = ok_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          ok_d       = 1'b1;
          ptr_d      = 1'b0;
          case (in_cmd_i)
            CMD_ALLOC: begin
              cmd_o.off_sel = OFF_ZERO;
              state_d       = S_A_RD;
            end
            CMD_FREE: begin
              state_d = sts_i.rel_ok ? S_FREE : S_DONE;
            end
            CMD_INIT: begin
              cmd_o.wr_sel = WR_INIT;
              state_d      = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_A_RD: begin
        if (sts_i.off_in) begin
          cmd_o.rd_sel = RD_OFF;
          state_d      = S_A_EV;
        end else begin
          ok_d    = 1'b0;
          state_d = S_DONE;
        end
      end
      S_A_EV: begin
        if (sts_i.fit) begin
          if (sts_i.split) begin
            cmd_o.wr_sel = WR_SPLIT;
            state_d      = S_A_WR;
          end else begin
            cmd_o.wr_sel = WR_TAKE;
            ptr_d        = 1'b1;
            state_d      = S_DONE;
          end
        end else if (sts_i.nxt_rd_in) begin
          cmd_o.rd_sel  = RD_NXT;
          cmd_o.off_sel = OFF_NXT_RD;
        end else begin
          ok_d    = 1'b0;
          state_d = S_DONE;
        end
      end
      S_A_WR: begin
        cmd_o.wr_sel = WR_TAKE;
        ptr_d        = 1'b1;
        state_d      = S_DONE;
      end
      S_FREE: begin
        cmd_o.wr_sel  = WR_FREEBIT;
        cmd_o.off_sel = OFF_ZERO;
        state_d       = S_M_RD;
      end
      S_M_RD: begin
        if (sts_i.off_in) begin
          cmd_o.rd_sel = RD_OFF;
          state_d      = S_M_EV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_M_EV: begin
        cmd_o.sz_ld = 1'b1;
        if (sts_i.nxt_rd_in) begin
          cmd_o.rd_sel = RD_NXT;
          if (sts_i.rd_free) begin
            state_d = S_M_EV2;
          end else begin
            cmd_o.off_sel = OFF_NXT_RD;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_M_EV2: begin
        if (sts_i.rd_free) begin
          cmd_o.wr_sel = WR_MERGE;
          state_d      = S_M_RD;
        end else begin
          // neighbor is in use: it becomes the current block, data already read
          cmd_o.off_sel = OFF_NXT_CUR;
          state_d       = S_M_EV;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_ld  = 1'b1;
          cmd_o.res_ok  = ok_q;
          cmd_o.res_ptr = ptr_q;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ok_q        <= 1'b1;
      ptr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ok_q        <= ok_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire
